@@ src/ldab_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line draw and alpha blend: shared package
// Sizes, operation and register codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ldab_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COORD_BITS = 16;

  localparam int FB_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(FB_DEPTH);
  localparam int ERR_W     = COORD_BITS + 3;
  localparam int LIM_W     = COORD_BITS + 6;
  localparam int DIM_W     = 9;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 4 * CH_W;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 2;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_ALPHA = 3'd5;

  typedef struct packed {
    logic [DIM_W-1:0] view_width;
    logic [DIM_W-1:0] view_height;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  alpha;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic clr_write;
    logic pix_read;
    logic pix_write;
    logic step;
    logic res_load;
    logic res_is_read;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_view;
    logic at_end;
  } sts_t;

endpackage
`default_nettype wire

@@ src/ldab_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line draw and alpha blend: controller
// Sequences the clearing sweep, the line walk, pixel reads and the hand-over
// of each result to the output register.
// ----------------------------------------------------------------------------
module ldab_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [ldab_pkg::OP_W-1:0] op,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output ldab_pkg::cmd_t                 cmd,
  input  wire ldab_pkg::sts_t            sts
);
  import ldab_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CLR  = 3'd2;
  localparam logic [2:0] S_DRAW = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_READ = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic [OP_W-1:0] op_q;
  logic            out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (op)
            OP_CLEAR: state_next = S_CLR;
            OP_DRAW:  state_next = S_DRAW;
            OP_READ:  state_next = S_READ;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = S_DONE;
        end
      end
      S_DRAW: begin
        if (sts.in_view) begin
          cmd.pix_read = 1'b1;
          state_next   = S_WR;
        end else if (sts.at_end) begin
          state_next = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_WR: begin
        cmd.pix_write = 1'b1;
        if (sts.at_end) begin
          state_next = S_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_DRAW;
        end
      end
      S_READ: begin
        cmd.pix_read = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.res_load    = 1'b1;
          cmd.res_is_read = (op_q == OP_READ);
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      op_q      <= OP_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        op_q <= op;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/ldab_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line draw and alpha blend: datapath
// Framebuffer memory, Bresenham stepping registers, clipping, the over blend
// and the result payload register.
// ----------------------------------------------------------------------------
module ldab_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire ldab_pkg::cmd_t                         cmd,
  output ldab_pkg::sts_t                              sts,
  input  wire ldab_pkg::cfg_t                         cfg,
  input  wire logic signed [ldab_pkg::COORD_BITS-1:0] x_start,
  input  wire logic signed [ldab_pkg::COORD_BITS-1:0] y_start,
  input  wire logic signed [ldab_pkg::COORD_BITS-1:0] x_end,
  input  wire logic signed [ldab_pkg::COORD_BITS-1:0] y_end,
  output logic [ldab_pkg::PIX_W-1:0]                  pixel_value,
  output logic                                        read_valid
);
  import ldab_pkg::*;

  // Exact floor(v / 255) for v up to 255 * 255.
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] v);
    logic [2*CH_W:0]   s;
    logic [3*CH_W:0]   p;
    s = {1'b0, v} + 17'd1;
    p = {8'd0, s} + {s, 8'd0};
    return p[3*CH_W-1:2*CH_W];
  endfunction

  function automatic logic [CH_W-1:0] premul(input logic [CH_W-1:0] c,
                                             input logic [CH_W-1:0] a);
    logic [2*CH_W-1:0] t;
    t = ({8'd0, c} * {8'd0, a}) + 16'd127;
    return div255(t);
  endfunction

  function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] src,
                                               input logic [CH_W-1:0] dst,
                                               input logic [CH_W-1:0] inv);
    logic [2*CH_W-1:0] t;
    t = {8'd0, dst} * {8'd0, inv};
    return src + div255(t);
  endfunction

  logic [PIX_W-1:0] mem [FB_DEPTH];
  logic [PIX_W-1:0] rd_data;

  logic signed [COORD_BITS-1:0] cx, cy, ex, ey;
  logic signed [COORD_BITS-1:0] cx_next, cy_next;
  logic                         sx_neg, sy_neg;
  logic signed [ERR_W-1:0]      dx, dy, err, err_next;
  logic signed [ERR_W:0]        e2;
  logic                         step_x, step_y;
  logic signed [COORD_BITS:0]   ddx, ddy, adx, ady;

  logic [CH_W-1:0]   pre_r, pre_g, pre_b, alpha, inv_alpha;
  logic [ADDR_W-1:0] clr_addr, pix_addr, wr_addr;
  logic [PIX_W-1:0]  wr_data, blend_px;
  logic              wr_en;
  logic              in_view, in_view_q;
  logic [LIM_W-1:0]  lim_w, lim_h, ux, uy;

  always_comb begin
    ddx = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
    ddy = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
    adx = ddx[COORD_BITS] ? -ddx : ddx;
    ady = ddy[COORD_BITS] ? -ddy : ddy;

    e2       = {err, 1'b0};
    step_x   = (e2 >= dy);
    step_y   = (e2 <= dx);
    err_next = err + (step_x ? dy : '0) + (step_y ? dx : '0);
    cx_next  = step_x ? (sx_neg ? cx - 1'b1 : cx + 1'b1) : cx;
    cy_next  = step_y ? (sy_neg ? cy - 1'b1 : cy + 1'b1) : cy;

    lim_w = (LIM_W'(cfg.view_width) < LIM_W'(MAX_WIDTH)) ?
            LIM_W'(cfg.view_width) : LIM_W'(MAX_WIDTH);
    lim_h = (LIM_W'(cfg.view_height) < LIM_W'(MAX_HEIGHT)) ?
            LIM_W'(cfg.view_height) : LIM_W'(MAX_HEIGHT);
    ux      = LIM_W'($unsigned(cx));
    uy      = LIM_W'($unsigned(cy));
    in_view = !cx[COORD_BITS-1] && !cy[COORD_BITS-1] && (ux < lim_w) && (uy < lim_h);
    pix_addr = ADDR_W'(uy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ux);

    blend_px = {blend_ch(alpha, rd_data[31:24], inv_alpha),
                blend_ch(pre_r, rd_data[23:16], inv_alpha),
                blend_ch(pre_g, rd_data[15:8], inv_alpha),
                blend_ch(pre_b, rd_data[7:0], inv_alpha)};

    wr_en   = cmd.clr_write || cmd.pix_write;
    wr_addr = cmd.clr_write ? clr_addr : pix_addr;
    wr_data = cmd.clr_write ? '0 : blend_px;
  end

  assign sts.clr_last = (clr_addr == ADDR_W'(FB_DEPTH - 1));
  assign sts.in_view  = in_view;
  assign sts.at_end   = (cx == ex) && (cy == ey);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.pix_read && in_view) begin
      rd_data <= mem[pix_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      cx       <= '0;
      cy       <= '0;
      err      <= '0;
    end else begin
      if (cmd.clr_write) begin
        clr_addr <= sts.clr_last ? '0 : clr_addr + 1'b1;
      end
      if (cmd.load) begin
        cx  <= x_start;
        cy  <= y_start;
        err <= ERR_W'(adx) - ERR_W'(ady);
      end else if (cmd.step) begin
        cx  <= cx_next;
        cy  <= cy_next;
        err <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ex        <= x_end;
      ey        <= y_end;
      dx        <= ERR_W'(adx);
      dy        <= -ERR_W'(ady);
      sx_neg    <= !(x_start < x_end);
      sy_neg    <= !(y_start < y_end);
      pre_r     <= premul(cfg.red, cfg.alpha);
      pre_g     <= premul(cfg.green, cfg.alpha);
      pre_b     <= premul(cfg.blue, cfg.alpha);
      alpha     <= cfg.alpha;
      inv_alpha <= 8'd255 - cfg.alpha;
    end
    if (cmd.pix_read) begin
      in_view_q <= in_view;
    end
    if (cmd.res_load) begin
      pixel_value <= (cmd.res_is_read && in_view_q) ? rd_data : '0;
      read_valid  <= cmd.res_is_read && in_view_q;
    end
  end

endmodule
`default_nettype wire

@@ src/line_draw_alpha_blend_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line draw and alpha blend core
// A 256 x 256 ARGB32 premultiplied framebuffer with clear, Bresenham line
// draw with Porter-Duff over blending, and pixel read.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time; every input transaction gives
// exactly one output transaction. After reset the framebuffer is swept to
// zero, one pixel per cycle, with in_ready low. A clear sweeps the whole
// framebuffer to zero the same way. A draw reads and then writes every pixel
// of the line that lies inside the view (the blend uses the registered read
// data) and skips every clipped pixel. The output register lets a new
// transaction be taken while the previous result waits on out_ready.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module line_draw_alpha_blend_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [ldab_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [ldab_pkg::CFG_W-1:0]             cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [ldab_pkg::OP_W-1:0]              op,
  input  wire logic signed [ldab_pkg::COORD_BITS-1:0] x_start,
  input  wire logic signed [ldab_pkg::COORD_BITS-1:0] y_start,
  input  wire logic signed [ldab_pkg::COORD_BITS-1:0] x_end,
  input  wire logic signed [ldab_pkg::COORD_BITS-1:0] y_end,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [ldab_pkg::PIX_W-1:0]                  pixel_value,
  output logic                                        read_valid
);
  import ldab_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_width  <= 9'd256;
      cfg.view_height <= 9'd256;
      cfg.red         <= 8'd0;
      cfg.green       <= 8'd0;
      cfg.blue        <= 8'd0;
      cfg.alpha       <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VIEW_WIDTH:  cfg.view_width  <= cfg_data;
        REG_VIEW_HEIGHT: cfg.view_height <= cfg_data;
        REG_COLOR_RED:   cfg.red         <= cfg_data[CH_W-1:0];
        REG_COLOR_GREEN: cfg.green       <= cfg_data[CH_W-1:0];
        REG_COLOR_BLUE:  cfg.blue        <= cfg_data[CH_W-1:0];
        REG_COLOR_ALPHA: cfg.alpha       <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  ldab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ldab_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg         (cfg),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .pixel_value (pixel_value),
    .read_valid  (read_valid)
  );

endmodule
`default_nettype wire
